// File: rtl/vnd_pkg.sv
// Shared types and constants for the vector normalize and distance unit.
// No dependencies; the interfaces and the top level in rtl refer to this package.
package vnd_pkg;

   localparam int FRAC_BITS_DEF       = 16;
   localparam int COMPONENT_WIDTH_DEF = 24;

   typedef enum logic [1:0] {
      OP_NORMALIZE = 2'd0,
      OP_DIRECTION = 2'd1,
      OP_LENGTH    = 2'd2,
      OP_DISTANCE  = 2'd3
   } op_type;

endpackage

// File: rtl/vnd_req_if.sv
// Valid/ready interface for the request word: operation code and vectors a and b.
// Depends on vnd_pkg for the default component width.
interface vnd_req_if #(
   parameter int COMPONENT_WIDTH = vnd_pkg::COMPONENT_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic [1:0]                        operation;
   logic signed [COMPONENT_WIDTH-1:0] a_x;
   logic signed [COMPONENT_WIDTH-1:0] a_y;
   logic signed [COMPONENT_WIDTH-1:0] a_z;
   logic signed [COMPONENT_WIDTH-1:0] b_x;
   logic signed [COMPONENT_WIDTH-1:0] b_y;
   logic signed [COMPONENT_WIDTH-1:0] b_z;

   modport source (output valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
   modport sink   (input valid, operation, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

// File: rtl/vnd_rsp_if.sv
// Valid/ready interface for the response word: result vector and length.
// Depends on vnd_pkg for the default component width.
interface vnd_rsp_if #(
   parameter int COMPONENT_WIDTH = vnd_pkg::COMPONENT_WIDTH_DEF
);
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] out_x;
   logic signed [COMPONENT_WIDTH-1:0] out_y;
   logic signed [COMPONENT_WIDTH-1:0] out_z;
   logic [COMPONENT_WIDTH:0]          magnitude;

   modport source (output valid, out_x, out_y, out_z, magnitude, input ready);
   modport sink   (input valid, out_x, out_y, out_z, magnitude, output ready);
endinterface

// File: rtl/vnd_isqrt.sv
// Pipelined integer square root, one result bit per stage, floored.
// A side bus travels alongside each word. No package dependencies.
module vnd_isqrt #(
   parameter int IN_W   = 52,
   parameter int SIDE_W = 8,
   localparam int RW    = IN_W / 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   in_sum,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [RW];
   logic [IN_W-1:0]   sum_ff   [RW];
   logic [RW+1:0]     rem_ff   [RW];
   logic [RW-1:0]     root_ff  [RW];
   logic [SIDE_W-1:0] side_ff  [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic              pv;
      logic [IN_W-1:0]   psum;
      logic [RW+1:0]     prem;
      logic [RW-1:0]     proot;
      logic [SIDE_W-1:0] pside;
      logic [RW+1:0]     rem_t;
      logic [RW+1:0]     trial;
      logic              ge;
      logic [RW+1:0]     rem_in;
      logic [RW-1:0]     root_in;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign psum  = in_sum;
         assign prem  = '0;
         assign proot = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = valid_ff[k-1];
         assign psum  = sum_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign pside = side_ff[k-1];
      end

      always_comb begin
         rem_t   = {prem[RW-1:0], psum[IN_W-1 -: 2]};
         trial   = {proot, 2'b01};
         ge      = (rem_t >= trial);
         rem_in  = ge ? (rem_t - trial) : rem_t;
         root_in = {proot[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= pv;
         end
         if (en) begin
            sum_ff[k]  <= psum << 2;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= pside;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_side  = side_ff[RW-1];

endmodule

// File: rtl/vnd_div.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
// Each numerator is assumed not to exceed the shared divisor. No package dependencies.
module vnd_div #(
   parameter int NW     = 25,
   parameter int DW     = 26,
   parameter int QW     = 17,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NW-1:0]     in_num [3],
   input  logic [DW-1:0]     in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [QW-1:0]     out_quot [3],
   output logic [DW-1:0]     out_den,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [QW];
   logic [DW-1:0]     den_ff   [QW];
   logic [SIDE_W-1:0] side_ff  [QW];
   logic [DW-1:0]     rem_ff   [QW][3];
   logic [QW-1:0]     quot_ff  [QW][3];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic              pv;
      logic [DW-1:0]     pden;
      logic [SIDE_W-1:0] pside;
      logic [DW:0]       t      [3];
      logic [QW-1:0]     pquot  [3];
      logic [DW-1:0]     rem_in [3];
      logic [QW-1:0]     quot_in[3];

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign pden  = in_den;
         assign pside = in_side;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign t[i]     = (DW+1)'(in_num[i]);
            assign pquot[i] = '0;
         end
      end else begin : g_next
         assign pv    = valid_ff[k-1];
         assign pden  = den_ff[k-1];
         assign pside = side_ff[k-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign t[i]     = {rem_ff[k-1][i], 1'b0};
            assign pquot[i] = quot_ff[k-1][i];
         end
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (t[i] >= {1'b0, pden}) begin
               rem_in[i]  = DW'(t[i] - {1'b0, pden});
               quot_in[i] = {pquot[i][QW-2:0], 1'b1};
            end else begin
               rem_in[i]  = DW'(t[i]);
               quot_in[i] = {pquot[i][QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= pv;
         end
         if (en) begin
            den_ff[k]  <= pden;
            side_ff[k] <= pside;
            for (int i = 0; i < 3; i++) begin
               rem_ff[k][i]  <= rem_in[i];
               quot_ff[k][i] <= quot_in[i];
            end
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_den   = den_ff[QW-1];
   assign out_side  = side_ff[QW-1];
   for (genvar i = 0; i < 3; i++) begin : g_out
      assign out_quot[i] = quot_ff[QW-1][i];
   end

endmodule

// File: rtl/vector3_normalize_distance.sv
// Fixed-point 3-vector normalize, direction, length and distance unit (top level).
// Depends on vnd_pkg, vnd_req_if, vnd_rsp_if, vnd_isqrt and vnd_div.
//
// The unit takes one request word per clock while responses are taken and returns one
// response word per request, in order. Three stages form the operand, the squares and their
// sum, the square root produces one bit per stage, the divider one quotient bit per stage,
// and the response sits in an output register. The whole pipeline holds while the response
// is not taken.
module vector3_normalize_distance #(
   parameter int FRAC_BITS       = vnd_pkg::FRAC_BITS_DEF,
   parameter int COMPONENT_WIDTH = vnd_pkg::COMPONENT_WIDTH_DEF
) (
   input logic      clock,
   input logic      reset,
   vnd_req_if.sink  req,
   vnd_rsp_if.source rsp
);

   localparam int CW     = COMPONENT_WIDTH;
   localparam int VW     = CW + 1;
   localparam int SQW    = 2 * VW;
   localparam int SUMW   = SQW + 2;
   localparam int RW     = SUMW / 2;
   localparam int QW     = FRAC_BITS + 1;
   localparam int SIDE_W = 2 + 3 * VW;
   localparam int EW     = ((QW + 1 > CW) ? QW + 1 : CW) + 1;
   localparam logic signed [EW-1:0] SAT_HI = EW'((64'd1 << (CW - 1)) - 64'd1);
   localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);
   localparam logic [RW-1:0] UNIT_LEN = RW'(1) << FRAC_BITS;

   logic en;
   assign en        = !rsp.valid || rsp.ready;
   assign req.ready = en;

   // Operand stage.
   logic signed [VW-1:0] a_ext [3];
   logic signed [VW-1:0] b_ext [3];
   logic signed [VW-1:0] v_in  [3];
   logic                 s1_valid_ff;
   logic [SIDE_W-1:0]    s1_side_ff;
   logic [SIDE_W-1:0]    s1_side_in;

   always_comb begin
      a_ext[0] = VW'(req.a_x);
      a_ext[1] = VW'(req.a_y);
      a_ext[2] = VW'(req.a_z);
      b_ext[0] = VW'(req.b_x);
      b_ext[1] = VW'(req.b_y);
      b_ext[2] = VW'(req.b_z);
      for (int i = 0; i < 3; i++) begin
         v_in[i] = req.operation[0] ? (a_ext[i] - b_ext[i]) : a_ext[i];
      end
      s1_side_in = {req.operation, v_in[0], v_in[1], v_in[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req.valid;
      end
      if (en) begin
         s1_side_ff <= s1_side_in;
      end
   end

   // Squaring stage.
   logic [VW-1:0]     s1_mag [3];
   logic              s2_valid_ff;
   logic [SIDE_W-1:0] s2_side_ff;
   logic [SQW-1:0]    s2_sq_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_mag[i] = s1_side_ff[(2 - i) * VW + VW - 1]
            ? VW'(-s1_side_ff[(2 - i) * VW +: VW]) : s1_side_ff[(2 - i) * VW +: VW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_side_ff <= s1_side_ff;
         for (int i = 0; i < 3; i++) begin
            s2_sq_ff[i] <= SQW'(s1_mag[i]) * SQW'(s1_mag[i]);
         end
      end
   end

   // Summing stage.
   logic              s3_valid_ff;
   logic [SIDE_W-1:0] s3_side_ff;
   logic [SUMW-1:0]   s3_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s3_side_ff <= s2_side_ff;
         s3_sum_ff  <= SUMW'(s2_sq_ff[0]) + SUMW'(s2_sq_ff[1]) + SUMW'(s2_sq_ff[2]);
      end
   end

   logic              sq_valid;
   logic [RW-1:0]     sq_root;
   logic [SIDE_W-1:0] sq_side;

   vnd_isqrt #(
      .IN_W   (SUMW),
      .SIDE_W (SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_sum    (s3_sum_ff),
      .in_side   (s3_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   logic [VW-1:0] sq_mag [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_mag[i] = sq_side[(2 - i) * VW + VW - 1]
            ? VW'(-sq_side[(2 - i) * VW +: VW]) : sq_side[(2 - i) * VW +: VW];
      end
   end

   logic              dv_valid;
   logic [QW-1:0]     dv_quot [3];
   logic [RW-1:0]     dv_len;
   logic [SIDE_W-1:0] dv_side;

   vnd_div #(
      .NW     (VW),
      .DW     (RW),
      .QW     (QW),
      .SIDE_W (SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_num    (sq_mag),
      .in_den    (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_den   (dv_len),
      .out_side  (dv_side)
   );

   // Result selection and saturation.
   vnd_pkg::op_type       dv_op;
   logic signed [VW-1:0]  dv_v    [3];
   logic signed [EW-1:0]  sv      [3];
   logic signed [CW-1:0]  comp_in [3];
   logic [CW:0]           mag_in;
   logic                  rsp_valid_ff;
   logic signed [CW-1:0]  comp_ff [3];
   logic [CW:0]           mag_ff;

   always_comb begin
      dv_op  = vnd_pkg::op_type'(dv_side[SIDE_W-1 -: 2]);
      mag_in = dv_len[RW-1] ? '1 : dv_len[CW:0];
      for (int i = 0; i < 3; i++) begin
         dv_v[i] = dv_side[(2 - i) * VW +: VW];
         sv[i]   = dv_v[i][VW-1] ? -EW'(dv_quot[i]) : EW'(dv_quot[i]);
         if (sv[i] > SAT_HI) begin
            comp_in[i] = CW'(SAT_HI);
         end else if (sv[i] < SAT_LO) begin
            comp_in[i] = CW'(SAT_LO);
         end else begin
            comp_in[i] = CW'(sv[i]);
         end
         if (dv_op == vnd_pkg::OP_LENGTH || dv_op == vnd_pkg::OP_DISTANCE
             || dv_len == '0) begin
            comp_in[i] = '0;
         end else if (dv_op == vnd_pkg::OP_NORMALIZE && dv_len == UNIT_LEN) begin
            comp_in[i] = CW'(dv_v[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (en) begin
         mag_ff <= mag_in;
         for (int i = 0; i < 3; i++) begin
            comp_ff[i] <= comp_in[i];
         end
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.out_x     = comp_ff[0];
   assign rsp.out_y     = comp_ff[1];
   assign rsp.out_z     = comp_ff[2];
   assign rsp.magnitude = mag_ff;

   // The length never reaches the top of its range.
   a_mag_range : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.magnitude != '1)
      else $error("magnitude reached saturation");

   // A zero length always comes with the zero vector.
   a_zero_len : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.magnitude == '0) |->
         (rsp.out_x == '0 && rsp.out_y == '0 && rsp.out_z == '0))
      else $error("non-zero vector with zero length");

   // A component never exceeds the length, so no quotient exceeds one.
   a_quot_bound : assert property (@(posedge clock) disable iff (reset)
      (dv_valid && dv_len != '0) |->
         (dv_quot[0] <= QW'(UNIT_LEN) && dv_quot[1] <= QW'(UNIT_LEN)
          && dv_quot[2] <= QW'(UNIT_LEN)))
      else $error("quotient above one");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the vector normalize, direction, length and distance unit.
// Depends on vnd_pkg, vnd_req_if, vnd_rsp_if and the vector3_normalize_distance RTL.
// A queue of request words drives the unit; each response word is checked against a predictor.
`timescale 1ns / 1ps

module testbench;

   localparam int CW = vnd_pkg::COMPONENT_WIDTH_DEF;
   localparam int FB = vnd_pkg::FRAC_BITS_DEF;
   localparam int LATENCY = 4 + (CW + 2) + (FB + 1);
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] C_ZERO = '0;
   localparam logic signed [CW-1:0] C_ONE = CW'(1 << FB);

   typedef struct packed {
      vnd_pkg::op_type operation;
      logic signed [CW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
   } request_type;

   typedef struct packed {
      logic signed [CW-1:0] out_x, out_y, out_z;
      logic [CW:0] magnitude;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   vnd_req_if #(.COMPONENT_WIDTH(CW)) req ();
   vnd_rsp_if #(.COMPONENT_WIDTH(CW)) rsp ();

   vector3_normalize_distance #(.FRAC_BITS(FB), .COMPONENT_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   request_type  pending_words[$];
   response_type expected_words[$];
   int errors = 0;
   int words_sent = 0;
   int words_checked = 0;
   bit calm = 1'b0;

   function automatic logic [127:0] isqrt(input logic [127:0] n);
      logic [127:0] r;
      logic [127:0] cand;
      r = 0;
      for (int b = 40; b >= 0; b--) begin
         cand = r | (128'd1 << b);
         if (cand * cand <= n) r = cand;
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] unit_component(input longint c,
                                                           input longint len);
      longint m;
      longint q;
      m = (c < 0) ? -c : c;
      q = (m << FB) / len;
      if (q > (longint'(1) << 40)) q = longint'(1) << 40;
      if (c < 0) q = -q;
      if (q > longint'(CMAX)) return CMAX;
      if (q < longint'(CMIN)) return CMIN;
      return q[CW-1:0];
   endfunction

   function automatic response_type predict_vector(input request_type w);
      response_type r;
      longint v[3];
      longint len;
      logic [127:0] sum;
      bit diff;
      diff = (w.operation == vnd_pkg::OP_DIRECTION) || (w.operation == vnd_pkg::OP_DISTANCE);
      v[0] = diff ? longint'(w.a_x) - longint'(w.b_x) : longint'(w.a_x);
      v[1] = diff ? longint'(w.a_y) - longint'(w.b_y) : longint'(w.a_y);
      v[2] = diff ? longint'(w.a_z) - longint'(w.b_z) : longint'(w.a_z);
      sum = 0;
      for (int i = 0; i < 3; i++) sum += 128'(v[i] * v[i]);
      len = longint'(isqrt(sum));
      r = '0;
      r.magnitude = len[CW:0];
      if ((w.operation == vnd_pkg::OP_NORMALIZE || w.operation == vnd_pkg::OP_DIRECTION)
          && len != 0) begin
         if (w.operation == vnd_pkg::OP_NORMALIZE && len == (longint'(1) << FB)) begin
            r.out_x = w.a_x;
            r.out_y = w.a_y;
            r.out_z = w.a_z;
         end else begin
            r.out_x = unit_component(v[0], len);
            r.out_y = unit_component(v[1], len);
            r.out_z = unit_component(v[2], len);
         end
      end
      return r;
   endfunction

   function automatic logic signed [CW-1:0] random_component();
      case ($urandom_range(0, 5))
         0: return CMAX;
         1: return CMIN;
         2: return $urandom_range(0, 1) ? $signed(CW'($urandom_range(0, 300))) :
                                         -$signed(CW'($urandom_range(0, 300)));
         3: return CW'($urandom_range(0, 2 << FB)) - C_ONE;
         default: return CW'($urandom);
      endcase
   endfunction

   function automatic request_type make_word(input vnd_pkg::op_type op,
                                             input logic signed [CW-1:0] ax, ay, az,
                                             input logic signed [CW-1:0] bx, by, bz);
      request_type w;
      w.operation = op;
      w.a_x = ax; w.a_y = ay; w.a_z = az;
      w.b_x = bx; w.b_y = by; w.b_z = bz;
      return w;
   endfunction

   // Driver: bursts of idling on the request side while not calm.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         {req.operation, req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z} <= '0;
      end else begin
         if (req.valid && req.ready) begin
            expected_words.push_back(predict_vector(pending_words.pop_front()));
            words_sent++;
         end
         if (!req.valid || req.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req.valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
               send_gap <= $urandom_range(0, 14);
               req.valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req.valid <= 1'b0;
            end else begin
               req.valid <= 1'b1;
               {req.operation, req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z}
                  <= pending_words[0];
            end
         end
      end
   end

   // Monitor: checks each response word and stalls the response side in bursts.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word x=%0d y=%0d z=%0d mag=%0d", $time,
                        rsp.out_x, rsp.out_y, rsp.out_z, rsp.magnitude);
               errors++;
            end else begin
               response_type e;
               e = expected_words.pop_front();
               if (e.out_x !== rsp.out_x)
                  $display("%0t: out_x expected %0d actual %0d", $time, e.out_x, rsp.out_x);
               if (e.out_y !== rsp.out_y)
                  $display("%0t: out_y expected %0d actual %0d", $time, e.out_y, rsp.out_y);
               if (e.out_z !== rsp.out_z)
                  $display("%0t: out_z expected %0d actual %0d", $time, e.out_z, rsp.out_z);
               if (e.magnitude !== rsp.magnitude)
                  $display("%0t: magnitude expected %0d actual %0d", $time,
                           e.magnitude, rsp.magnitude);
               if (e !== {rsp.out_x, rsp.out_y, rsp.out_z, rsp.magnitude}) errors++;
               words_checked++;
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 14);
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < 4; k++) begin
         vnd_pkg::op_type op;
         op = vnd_pkg::op_type'(k);
         pending_words.push_back(make_word(op, C_ZERO, C_ZERO, C_ZERO,
                                           C_ZERO, C_ZERO, C_ZERO));
         pending_words.push_back(make_word(op, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN));
         pending_words.push_back(make_word(op, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX));
         pending_words.push_back(make_word(op, C_ONE, C_ZERO, C_ZERO,
                                           C_ZERO, C_ZERO, C_ZERO));
         pending_words.push_back(make_word(op, C_ZERO, -C_ONE, C_ZERO,
                                           C_ZERO, C_ZERO, C_ZERO));
         pending_words.push_back(make_word(op, CW'(1), CW'(-1), CW'(1),
                                           CW'(5), CW'(5), CW'(5)));
      end
      pending_words.push_back(make_word(vnd_pkg::OP_DIRECTION, CW'(7), CW'(7), CW'(7),
                                        CW'(7), CW'(7), CW'(7)));
      pending_words.push_back(make_word(vnd_pkg::OP_NORMALIZE, CW'(1), C_ZERO, C_ZERO,
                                        C_ZERO, C_ZERO, C_ZERO));

      // Let everything drain before the random part.
      wait (pending_words.size() == 0 && expected_words.size() == 0);

      for (int n = 0; n < 800; n++) begin
         vnd_pkg::op_type op;
         logic signed [CW-1:0] ax, ay, az;
         op = vnd_pkg::op_type'($urandom_range(0, 3));
         ax = random_component(); ay = random_component(); az = random_component();
         if ($urandom_range(0, 9) == 0)
            pending_words.push_back(make_word(op, ax, ay, az, ax, ay, az));
         else
            pending_words.push_back(make_word(op, ax, ay, az, random_component(),
                                              random_component(), random_component()));
         if (n == 400) begin
            wait (pending_words.size() == 0 && expected_words.size() == 0);
         end
         if (n == 650) calm = 1'b1;
      end

      wait (pending_words.size() == 0 && expected_words.size() == 0);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d words over all four operations, with extremes, zero and unit lengths;",
               words_sent);
      $display("%0d response words checked under random idling and stalls.", words_checked);
      if (errors == 0 && expected_words.size() == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin
      #200000;
      $display("testbench: errors");
      $finish;
   end

endmodule

// File: sim.f
rtl/vnd_pkg.sv
rtl/vnd_req_if.sv
rtl/vnd_rsp_if.sv
rtl/vnd_isqrt.sv
rtl/vnd_div.sv
rtl/vector3_normalize_distance.sv
verif/testbench.sv
